>>> design/msa_pkg.sv
package msa_pkg;

    // Widths of the result fields.
    localparam int AREA_W  = 64;
    localparam int COUNT_W = 32;

    // Cross product component selected for a multiply.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Role of a cross product term: first term or subtracted term.
    localparam logic [1:0] PART_PLUS  = 2'd0;
    localparam logic [1:0] PART_MINUS = 2'd1;

    // Partial products of a squared magnitude split into high and low halves.
    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    // Tag that travels with each product through the shared multiplier.
    typedef struct packed {
        logic       sq;
        logic [1:0] comp;
        logic [1:0] part;
    } t_mul_tag;

    // Status of the square root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_status;

endpackage

>>> design/mesh_surface_area_accumulator_core.sv
// Triangle mesh surface area accumulator.
// Input channel: one transfer carries one triangle as three vertices (i_ax .. i_cz,
// signed fixed point, Q8.8 at the default width) and the i_last_triangle flag.
// Output channel: one transfer per mesh, after the triangle flagged last, with the
// saturating area total (17 fraction bits) and the saturating triangle count.
// Each triangle runs through a sequencer that issues 15 products to one shared
// registered multiplier (six cross product terms, nine partial squares), then a
// square root unit that resolves one root bit per cycle.
// An accepted triangle keeps o_in_stall high until it has been added to the sum, so
// the block takes no new triangle before it is through with the last one; the root
// iterations take most of that time. A result shows on o_out_valid once the last
// triangle of its mesh has been through the root unit and added to the sum.
// The result sits in an output register; while the receiver stalls it holds still
// and the next triangles are still taken. Only when a second result is ready
// before the first one left does the block wait for the receiver.
// Reset clears the running sum, the count and the result valid flag; o_in_stall is
// high while reset is asserted.
module mesh_surface_area_accumulator_core
    import msa_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by_coord,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    input  logic                          i_last_triangle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [AREA_W-1:0]             o_area_total,
    output logic [COUNT_W-1:0]            o_triangle_count
);

    // Edge vector components, multiplier operands, cross product components,
    // their magnitudes and the halves of a magnitude.
    localparam int DW   = COORD_WIDTH + 1;
    localparam int OPW  = COORD_WIDTH + 2;
    localparam int PW   = 2 * OPW;
    localparam int KW   = 2 * COORD_WIDTH + 3;
    localparam int MW   = KW - 1;
    localparam int HW   = COORD_WIDTH + 1;
    localparam int RW   = KW;
    localparam int RADW = 2 * RW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CROSS  = 3'd1;
    localparam logic [2:0] ST_MAGW   = 3'd2;
    localparam logic [2:0] ST_MAG    = 3'd3;
    localparam logic [2:0] ST_SQUARE = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_ROOT   = 3'd6;
    localparam logic [2:0] ST_ACC    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_comp;
    logic [1:0] r_part;
    logic       r_last;
    logic       r_root_start;

    logic signed [DW-1:0] r_u [3];
    logic signed [DW-1:0] r_v [3];
    logic signed [KW-1:0] r_k [3];
    logic [MW-1:0]        r_mag [3];
    logic [RADW-1:0]      r_rad;

    logic [AREA_W-1:0]  r_area;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [AREA_W-1:0]  r_out_area;
    logic [COUNT_W-1:0] r_out_count;

    logic                  w_accept;
    logic                  w_iss_valid;
    t_mul_tag              w_iss_tag;
    logic signed [OPW-1:0] w_op_a;
    logic signed [OPW-1:0] w_op_b;
    logic [MW-1:0]         w_mag_sel;
    logic                  w_prod_valid;
    t_mul_tag              w_prod_tag;
    logic signed [PW-1:0]  w_prod;
    logic [RADW-1:0]       w_sq_ext;
    logic [KW-1:0]         w_neg [3];
    t_sqrt_status          w_sqrt_st;
    logic [RW-1:0]         w_root;
    logic [AREA_W:0]       w_sum_ext;
    logic [AREA_W-1:0]     w_sum_sat;
    logic [COUNT_W-1:0]    w_cnt_next;
    logic                  w_out_free;
    logic                  w_emit;

    assign o_in_stall = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;

    // The result register can take a new value when it is empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_state == ST_ACC) && r_last && w_out_free;

    // Sequencer. Products leave the multiplier in the cycle after issue; the wait
    // states give the last cross product and the last square time to land.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_CROSS;
            end
            ST_CROSS: begin
                if (r_comp == COMP_Z && r_part == PART_MINUS) n_state = ST_MAGW;
            end
            ST_MAGW:   n_state = ST_MAG;
            ST_MAG:    n_state = ST_SQUARE;
            ST_SQUARE: begin
                if (r_comp == COMP_Z && r_part == PART_HH) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_sqrt_st.done && !w_sqrt_st.busy) n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!r_last || w_out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_iss_valid    = 1'b0;
        w_iss_tag.sq   = (r_state == ST_SQUARE);
        w_iss_tag.comp = r_comp;
        w_iss_tag.part = r_part;
        w_op_a         = '0;
        w_op_b         = '0;
        case (r_comp)
            COMP_X:  w_mag_sel = r_mag[0];
            COMP_Y:  w_mag_sel = r_mag[1];
            COMP_Z:  w_mag_sel = r_mag[2];
            default: w_mag_sel = '0;
        endcase
        if (r_state == ST_CROSS) begin
            w_iss_valid = 1'b1;
            // x: uy*vz - uz*vy, y: uz*vx - ux*vz, z: ux*vy - uy*vx
            case (r_comp)
                COMP_X: begin
                    w_op_a = (r_part == PART_PLUS) ? {r_u[1][DW-1], r_u[1]}
                                                   : {r_u[2][DW-1], r_u[2]};
                    w_op_b = (r_part == PART_PLUS) ? {r_v[2][DW-1], r_v[2]}
                                                   : {r_v[1][DW-1], r_v[1]};
                end
                COMP_Y: begin
                    w_op_a = (r_part == PART_PLUS) ? {r_u[2][DW-1], r_u[2]}
                                                   : {r_u[0][DW-1], r_u[0]};
                    w_op_b = (r_part == PART_PLUS) ? {r_v[0][DW-1], r_v[0]}
                                                   : {r_v[2][DW-1], r_v[2]};
                end
                COMP_Z: begin
                    w_op_a = (r_part == PART_PLUS) ? {r_u[0][DW-1], r_u[0]}
                                                   : {r_u[1][DW-1], r_u[1]};
                    w_op_b = (r_part == PART_PLUS) ? {r_v[1][DW-1], r_v[1]}
                                                   : {r_v[0][DW-1], r_v[0]};
                end
                default: begin
                    w_op_a = '0;
                    w_op_b = '0;
                end
            endcase
        end else if (r_state == ST_SQUARE) begin
            // The magnitude is too wide for one product, so it is squared as
            // low*low, high*low (counted twice) and high*high.
            w_iss_valid = 1'b1;
            case (r_part)
                PART_LL: begin
                    w_op_a = {1'b0, w_mag_sel[HW-1:0]};
                    w_op_b = {1'b0, w_mag_sel[HW-1:0]};
                end
                PART_HL: begin
                    w_op_a = {1'b0, w_mag_sel[MW-1:HW]};
                    w_op_b = {1'b0, w_mag_sel[HW-1:0]};
                end
                PART_HH: begin
                    w_op_a = {1'b0, w_mag_sel[MW-1:HW]};
                    w_op_b = {1'b0, w_mag_sel[MW-1:HW]};
                end
                default: begin
                    w_op_a = '0;
                    w_op_b = '0;
                end
            endcase
        end
    end

    msa_mul #(
        .OPW(OPW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_iss_valid),
        .i_tag   (w_iss_tag),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_valid (w_prod_valid),
        .o_tag   (w_prod_tag),
        .o_prod  (w_prod)
    );

    msa_isqrt #(
        .RW(RW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_root_start),
        .i_radicand (r_rad),
        .o_status   (w_sqrt_st),
        .o_root     (w_root)
    );

    // Partial squares are non-negative and fit in the low MW product bits.
    assign w_sq_ext = {{(RADW-MW){1'b0}}, w_prod[MW-1:0]};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_neg[c] = -r_k[c];
        end
    end

    // Saturating running sum and count for the triangle that just finished.
    assign w_sum_ext  = {1'b0, r_area} + {{(AREA_W+1-RW){1'b0}}, w_root};
    assign w_sum_sat  = w_sum_ext[AREA_W] ? {AREA_W{1'b1}} : w_sum_ext[AREA_W-1:0];
    assign w_cnt_next = (r_count == {COUNT_W{1'b1}}) ? r_count : r_count + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_root_start <= 1'b0;
            r_area       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_root_start <= (r_state == ST_DRAIN);
            if (r_state == ST_ACC) begin
                if (!r_last) begin
                    r_area  <= w_sum_sat;
                    r_count <= w_cnt_next;
                end else if (w_out_free) begin
                    r_area  <= '0;
                    r_count <= '0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_emit) begin
            r_out_area  <= w_sum_sat;
            r_out_count <= w_cnt_next;
        end

        // Edge vectors AB and AC, one bit wider than a coordinate.
        if (w_accept) begin
            r_u[0] <= {i_bx[COORD_WIDTH-1], i_bx} - {i_ax[COORD_WIDTH-1], i_ax};
            r_u[1] <= {i_by_coord[COORD_WIDTH-1], i_by_coord}
                      - {i_ay[COORD_WIDTH-1], i_ay};
            r_u[2] <= {i_bz[COORD_WIDTH-1], i_bz} - {i_az[COORD_WIDTH-1], i_az};
            r_v[0] <= {i_cx[COORD_WIDTH-1], i_cx} - {i_ax[COORD_WIDTH-1], i_ax};
            r_v[1] <= {i_cy[COORD_WIDTH-1], i_cy} - {i_ay[COORD_WIDTH-1], i_ay};
            r_v[2] <= {i_cz[COORD_WIDTH-1], i_cz} - {i_az[COORD_WIDTH-1], i_az};
            r_last <= i_last_triangle;
            r_comp <= COMP_X;
            r_part <= PART_PLUS;
        end else if (r_state == ST_CROSS) begin
            if (r_part == PART_MINUS) begin
                r_part <= PART_PLUS;
                r_comp <= (r_comp == COMP_Z) ? COMP_X : r_comp + 2'd1;
            end else begin
                r_part <= PART_MINUS;
            end
        end else if (r_state == ST_SQUARE) begin
            if (r_part == PART_HH) begin
                r_part <= PART_LL;
                r_comp <= (r_comp == COMP_Z) ? COMP_X : r_comp + 2'd1;
            end else begin
                r_part <= r_part + 2'd1;
            end
        end

        if (r_state == ST_MAG) begin
            for (int c = 0; c < 3; c++) begin
                r_mag[c] <= r_k[c][KW-1] ? w_neg[c][MW-1:0] : r_k[c][MW-1:0];
            end
        end

        // Products come back tagged with where they belong.
        if (w_accept) begin
            r_rad <= '0;
        end else if (w_prod_valid && w_prod_tag.sq) begin
            case (w_prod_tag.part)
                PART_LL: r_rad <= r_rad + w_sq_ext;
                PART_HL: r_rad <= r_rad + (w_sq_ext << (HW + 1));
                PART_HH: r_rad <= r_rad + (w_sq_ext << (2 * HW));
                default: r_rad <= r_rad;
            endcase
        end
        if (w_prod_valid && !w_prod_tag.sq) begin
            for (int c = 0; c < 3; c++) begin
                if (w_prod_tag.comp == 2'(c)) begin
                    if (w_prod_tag.part == PART_PLUS) begin
                        r_k[c] <= w_prod[KW-1:0];
                    end else begin
                        r_k[c] <= r_k[c] - w_prod[KW-1:0];
                    end
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_area_total     = r_out_area;
    assign o_triangle_count = r_out_count;

endmodule

>>> design/msa_mul.sv
module msa_mul
    import msa_pkg::*;
#(
    parameter int OPW = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_mul_tag                i_tag,
    input  logic signed [OPW-1:0]   i_a,
    input  logic signed [OPW-1:0]   i_b,
    output logic                    o_valid,
    output t_mul_tag                o_tag,
    output logic signed [2*OPW-1:0] o_prod
);

    logic                    r_valid;
    t_mul_tag                r_tag;
    logic signed [2*OPW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_tag  <= i_tag;
        r_prod <= i_a * i_b;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_prod  = r_prod;

endmodule

>>> design/msa_isqrt.sv
module msa_isqrt
    import msa_pkg::*;
#(
    parameter int RW = 35
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_radicand,
    output t_sqrt_status    o_status,
    output logic [RW-1:0]   o_root
);

    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] r_rad;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW+2:0] w_rem_sh;
    logic [RW+2:0] w_trial;
    logic [RW+2:0] w_diff;
    logic          w_take;

    // One root bit per cycle: bring down two radicand bits, try (root*4 + 1).
    always_comb begin
        w_rem_sh = {r_rem, r_rad[2*RW-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_take   = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CW'(RW);
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_take ? w_diff[RW:0] : w_rem_sh[RW:0];
            r_root <= {r_root[RW-2:0], w_take};
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_root        = r_root;

endmodule

>>> design/msa_checker.sv
module msa_checker
    import msa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [AREA_W-1:0]  o_area_total,
    input logic [COUNT_W-1:0] o_triangle_count
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_area_total) && $stable(o_triangle_count))
        else $error("result changed while stalled");

    // A triangle occupies the block after its transfer, so the input stays stalled.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("input taken again too soon");

    // Every result covers at least the triangle flagged last.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_triangle_count != '0)
        else $error("result with zero triangles");

    // A new result only comes out of a triangle in progress.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no triangle in progress");

endmodule

bind mesh_surface_area_accumulator_core msa_checker u_msa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_area_total     (o_area_total),
    .o_triangle_count (o_triangle_count)
);
